### rtl/core/mrba_pkg.sv
// Shared types and constants for the multi-region bump allocator.
package mrba_pkg;

    localparam int MaxAreas  = 16;
    localparam int AreaBits  = $clog2(MaxAreas);
    localparam int CountBits = $clog2(MaxAreas + 1);
    localparam int AddrBits  = 16;
    localparam int PtrBits   = AddrBits + 1;
    localparam int ZpLimit   = 255;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OOM  = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_ALLOC = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_PREF,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic                opcode;
        logic [AddrBits-1:0] start_addr;
        logic [AddrBits-1:0] end_addr;
        logic                use_preferred;
        logic [AreaBits-1:0] preferred_area;
        logic [15:0]         alloc_size;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic [AreaBits-1:0] granted_area;
        logic [AddrBits-1:0] granted_addr;
        logic                not_zeropage;
    } t_result;

    typedef struct packed {
        logic latch;
        logic add;
        logic grant;
        logic oom;
        logic seek_first;
        logic advance;
    } t_dp_cmd;

    typedef struct packed {
        logic pref_hit;
        logic in_range;
        logic fit;
    } t_dp_stat;

endpackage

### rtl/core/mrba_ctrl.sv
// Controller state machine for the multi-region bump allocator.
module mrba_ctrl
    import mrba_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_opcode,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = (t_opcode'(i_opcode) == OP_ADD) ? S_ADD : S_PREF;
                end
            end
            S_ADD: begin
                n_state = S_IDLE;
            end
            S_PREF: begin
                n_state = i_stat.pref_hit ? S_IDLE : S_SCAN;
            end
            S_SCAN: begin
                if (!i_stat.in_range || i_stat.fit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_busy      = 1'b0;
                o_cmd.latch = i_start;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
            end
            S_PREF: begin
                if (i_stat.pref_hit) begin
                    o_cmd.grant = 1'b1;
                end else begin
                    o_cmd.seek_first = 1'b1;
                end
            end
            S_SCAN: begin
                priority if (!i_stat.in_range) begin
                    o_cmd.oom = 1'b1;
                end else if (i_stat.fit) begin
                    o_cmd.grant = 1'b1;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

### rtl/core/mrba_dp.sv
// Datapath: region table, fit test, scan index and result register.
module mrba_dp
    import mrba_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_req                i_req,
    input  logic                i_cfg_we,
    input  logic [AreaBits-1:0] i_cfg_wdata,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    output t_result             o_result,
    output logic                o_result_valid
);

    logic [AddrBits-1:0]  r_end_mem [MaxAreas];
    logic [PtrBits-1:0]   r_free_mem [MaxAreas];
    logic [CountBits-1:0] r_count;
    logic [AreaBits-1:0]  r_first_area;
    logic [CountBits-1:0] r_idx;
    logic [CountBits-1:0] n_idx;
    logic [AddrBits-1:0]  r_rd_end;
    logic [PtrBits-1:0]   r_rd_free;

    logic [AddrBits-1:0]  r_start;
    logic [AddrBits-1:0]  r_end;
    logic                 r_use_pref;
    logic [15:0]          r_size;

    t_result              r_result;
    logic                 r_valid;

    logic [AreaBits-1:0]  idx;
    logic [PtrBits-1:0]   cur_free;
    logic [PtrBits:0]     sum;
    logic [PtrBits-1:0]   limit;
    logic                 table_full;
    logic [AreaBits-1:0]  wr_idx;

    assign idx        = r_idx[AreaBits-1:0];
    assign wr_idx     = r_count[AreaBits-1:0];
    assign cur_free   = r_rd_free;
    assign sum        = {1'b0, cur_free} + (PtrBits + 1)'(r_size);
    assign limit      = {1'b0, r_rd_end} + PtrBits'(1);
    assign table_full = (r_count >= CountBits'(MaxAreas));

    assign o_stat.in_range = (r_idx < r_count);
    assign o_stat.fit      = (sum <= {1'b0, limit});
    assign o_stat.pref_hit = r_use_pref && o_stat.in_range && o_stat.fit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_area <= '0;
        end else if (i_cfg_we) begin
            r_first_area <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.add && !table_full) begin
            r_count <= r_count + CountBits'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add && !table_full) begin
            r_end_mem[wr_idx]  <= r_end;
            r_free_mem[wr_idx] <= PtrBits'(r_start);
        end else if (i_cmd.grant) begin
            r_free_mem[idx] <= sum[PtrBits-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_start    <= i_req.start_addr;
            r_end      <= i_req.end_addr;
            r_use_pref <= i_req.use_preferred;
            r_size     <= i_req.alloc_size;
        end
    end

    // table is read at the index taken next, so the data lines up with r_idx
    always_comb begin
        n_idx = r_idx;
        if (i_cmd.latch) begin
            n_idx = CountBits'(i_req.preferred_area);
        end else if (i_cmd.seek_first) begin
            n_idx = CountBits'(r_first_area);
        end else if (i_cmd.advance) begin
            n_idx = r_idx + CountBits'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_rd_end  <= r_end_mem[n_idx[AreaBits-1:0]];
        r_rd_free <= r_free_mem[n_idx[AreaBits-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.add || i_cmd.grant || i_cmd.oom;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add) begin
            if (table_full) begin
                r_result.status       <= ST_FULL;
                r_result.granted_area <= '0;
                r_result.granted_addr <= '0;
                r_result.not_zeropage <= 1'b0;
            end else begin
                r_result.status       <= ST_OK;
                r_result.granted_area <= wr_idx;
                r_result.granted_addr <= r_start;
                r_result.not_zeropage <= (r_count == '0) && (r_end > AddrBits'(ZpLimit));
            end
        end else if (i_cmd.grant) begin
            r_result.status       <= ST_OK;
            r_result.granted_area <= idx;
            r_result.granted_addr <= cur_free[AddrBits-1:0];
            r_result.not_zeropage <= 1'b0;
        end else if (i_cmd.oom) begin
            r_result.status       <= ST_OOM;
            r_result.granted_area <= '0;
            r_result.granted_addr <= '1;
            r_result.not_zeropage <= 1'b0;
        end
    end

    assign o_result       = r_result;
    assign o_result_valid = r_valid;

endmodule

### rtl/core/multi_region_bump_allocator_unit.sv
// Multi-region bump allocator: top level joining controller and datapath.
// Add request: the controller passes through S_ADD and the result strobe is registered from it;
// a new start is accepted in the same cycle as the strobe. Allocate: S_PREF tests the preferred
// region and grants on a hit; else S_SCAN tests regions in turn from first_area, granting the first that fits, or OOM.
// Throughput: one request at a time; busy high from the cycle after accept to the result.
// Synchronous active-low reset empties the region table, first_area to 0; no result stall.
module multi_region_bump_allocator_unit
    import mrba_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  t_req                i_req,
    input  logic                i_cfg_we,
    input  logic [AreaBits-1:0] i_cfg_wdata,
    output t_result             o_result,
    output logic                o_result_valid
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    mrba_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_req.opcode),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    mrba_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (i_req),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

`ifndef NO_ASSERTIONS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result without a request in progress");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for two cycles");

    a_oom_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.status == ST_OOM) |->
            (o_result.granted_addr == '1 && o_result.granted_area == '0))
        else $error("out-of-memory result with wrong fields");
`endif

endmodule
